// ===== hw/rtl/escape_time_fractal_pixel_macros.svh =====
// Assertion macros shared by the escape-time fractal pixel block.
// Depends on nothing; included by the top level only.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define ETF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock, off during reset.
`define ETF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/etf_pkg.sv =====
// Package for the escape-time fractal pixel block: constants, types and
// fixed-point helper functions. Depends on nothing.
package etf_pkg;

  // Fixed-point format and field widths.
  localparam int unsigned FracBits    = 26;
  localparam int unsigned WordW       = 32;
  localparam int unsigned ProdW       = 2 * WordW;
  localparam int unsigned AccW        = ProdW + 1;
  localparam int unsigned CoordW      = 16;
  localparam int unsigned CountW      = 20;
  localparam int unsigned ExpW        = 4;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned MaxExponent = 8;
  localparam int unsigned EscBit      = 2 * FracBits + 1;
  localparam int unsigned TestW       = 8;

  localparam logic [CountW-1:0]       LimitCap  = CountW'(1000000);
  localparam logic signed [WordW-1:0] OneFix    = WordW'(1) << FracBits;
  localparam logic [CountW-1:0]       LimitRst  = CountW'(256);
  localparam logic [ExpW-1:0]         ExpRst    = ExpW'(2);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegOriginReal = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginImag = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepReal   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepImag   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIterLimit  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMode       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegExponent   = 3'd6;

  typedef enum logic [1:0] {
    MODE_ZERO  = 2'd0,
    MODE_QUAD  = 2'd1,
    MODE_POWER = 2'd2,
    MODE_TEST  = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [WordW-1:0] origin_real;
    logic signed [WordW-1:0] origin_imag;
    logic signed [WordW-1:0] step_real;
    logic signed [WordW-1:0] step_imag;
    logic [CountW-1:0]       iteration_limit;
    mode_e                   mode;
    logic [ExpW-1:0]         exponent;
  } cfg_t;

  // Operand pairs for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_X_SR  = 4'd0,
    MUL_Y_SI  = 4'd1,
    MUL_XY    = 4'd2,
    MUL_PR_ZR = 4'd3,
    MUL_PI_ZI = 4'd4,
    MUL_PR_ZI = 4'd5,
    MUL_PI_ZR = 4'd6,
    MUL_ZR_ZR = 4'd7,
    MUL_ZI_ZI = 4'd8
  } mul_sel_e;

  // Sources for the result register.
  typedef enum logic [1:0] {
    RES_ZERO      = 2'd0,
    RES_TEST      = 2'd1,
    RES_COUNT     = 2'd2,
    RES_COUNT_INC = 2'd3
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_xy;
    mul_sel_e mul_sel;
    logic     acc_load;
    logic     cr_load;
    logic     ci_load;
    logic     p_load;
    logic     p_one;
    logic     pr_cmul;
    logic     pi_cmul;
    logic     z_clear;
    logic     z_update;
    logic     cnt_clear;
    logic     cnt_inc;
    logic     res_load;
    res_sel_e res_sel;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escaped;
    logic cnt_last;
    logic limit_zero;
  } sts_t;

  // Saturate a wide signed value to one word.
  function automatic logic signed [WordW-1:0] sat_word(input logic signed [AccW-1:0] v);
    logic [AccW-WordW:0] hi;
    hi = v[AccW-1:WordW-1];
    if ((&hi) || (~|hi)) begin
      return v[WordW-1:0];
    end else if (v[AccW-1]) begin
      return {1'b1, {(WordW-1){1'b0}}};
    end else begin
      return {1'b0, {(WordW-1){1'b1}}};
    end
  endfunction

  // Floor shift by the fraction width, then saturate.
  function automatic logic signed [WordW-1:0] shift_sat(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] s;
    s = v >>> FracBits;
    return sat_word(s);
  endfunction

endpackage

// ===== hw/rtl/etf_cfg.sv =====
// Configuration register file of the escape-time fractal pixel block.
// Depends on etf_pkg for the register indexes and the cfg_t type.
module etf_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [etf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [etf_pkg::WordW-1:0]     cfg_wdata_i,
  output etf_pkg::cfg_t                 cfg_o
);

  etf_pkg::cfg_t cfg_q, cfg_d;

  // Decode a write into the addressed register; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        etf_pkg::RegOriginReal: cfg_d.origin_real = cfg_wdata_i;
        etf_pkg::RegOriginImag: cfg_d.origin_imag = cfg_wdata_i;
        etf_pkg::RegStepReal:   cfg_d.step_real   = cfg_wdata_i;
        etf_pkg::RegStepImag:   cfg_d.step_imag   = cfg_wdata_i;
        etf_pkg::RegIterLimit:  cfg_d.iteration_limit = cfg_wdata_i[etf_pkg::CountW-1:0];
        etf_pkg::RegMode:       cfg_d.mode = etf_pkg::mode_e'(cfg_wdata_i[1:0]);
        etf_pkg::RegExponent:   cfg_d.exponent = cfg_wdata_i[etf_pkg::ExpW-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // Register storage with the documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_real     <= '0;
      cfg_q.origin_imag     <= '0;
      cfg_q.step_real       <= '0;
      cfg_q.step_imag       <= '0;
      cfg_q.iteration_limit <= etf_pkg::LimitRst;
      cfg_q.mode            <= etf_pkg::MODE_QUAD;
      cfg_q.exponent        <= etf_pkg::ExpRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/etf_dp.sv =====
// Datapath of the escape-time fractal pixel block: one shared 32x32
// multiplier, an accumulator, the point and orbit registers and the result.
// Depends on etf_pkg; driven by commands from etf_ctrl.
module etf_dp (
  input  logic                        clk_i,
  input  etf_pkg::cfg_t               cfg_i,
  input  logic [etf_pkg::CoordW-1:0]  pixel_x_i,
  input  logic [etf_pkg::CoordW-1:0]  pixel_y_i,
  input  etf_pkg::cmd_t               cmd_i,
  output etf_pkg::sts_t               sts_o,
  output logic [etf_pkg::CountW-1:0]  iteration_count_o
);

  logic [etf_pkg::CoordW-1:0]       x_q, y_q;
  logic signed [etf_pkg::WordW-1:0] cr_q, ci_q, zr_q, zi_q, pr_q, pi_q;
  logic signed [etf_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [etf_pkg::AccW-1:0]  acc_q, prod_ext, sum_val, diff_val;
  logic [etf_pkg::CountW-1:0]       count_q, res_q, out_q, limit_eff, res_d;
  logic signed [etf_pkg::WordW-1:0] mul_a, mul_b, x_word, y_word;

  assign x_word = {{(etf_pkg::WordW-etf_pkg::CoordW){1'b0}}, x_q};
  assign y_word = {{(etf_pkg::WordW-etf_pkg::CoordW){1'b0}}, y_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.mul_sel)
      etf_pkg::MUL_X_SR:  begin mul_a = x_word; mul_b = cfg_i.step_real; end
      etf_pkg::MUL_Y_SI:  begin mul_a = y_word; mul_b = cfg_i.step_imag; end
      etf_pkg::MUL_XY:    begin mul_a = x_word; mul_b = y_word; end
      etf_pkg::MUL_PR_ZR: begin mul_a = pr_q;   mul_b = zr_q; end
      etf_pkg::MUL_PI_ZI: begin mul_a = pi_q;   mul_b = zi_q; end
      etf_pkg::MUL_PR_ZI: begin mul_a = pr_q;   mul_b = zi_q; end
      etf_pkg::MUL_PI_ZR: begin mul_a = pi_q;   mul_b = zr_q; end
      etf_pkg::MUL_ZR_ZR: begin mul_a = zr_q;   mul_b = zr_q; end
      etf_pkg::MUL_ZI_ZI: begin mul_a = zi_q;   mul_b = zi_q; end
      default:            begin mul_a = zr_q;   mul_b = zr_q; end
    endcase
  end

  assign prod_d   = mul_a * mul_b;
  assign prod_ext = {prod_q[etf_pkg::ProdW-1], prod_q};
  assign sum_val  = acc_q + prod_ext;
  assign diff_val = acc_q - prod_ext;

  // Iteration limit, capped at its documented maximum.
  assign limit_eff = (cfg_i.iteration_limit > etf_pkg::LimitCap) ?
                     etf_pkg::LimitCap : cfg_i.iteration_limit;

  // Status: the escape test reads the sum of both squares, which is never negative.
  assign sts_o.escaped    = |sum_val[etf_pkg::AccW-1:etf_pkg::EscBit];
  assign sts_o.cnt_last   = ({1'b0, count_q} + (etf_pkg::CountW+1)'(1)) == {1'b0, limit_eff};
  assign sts_o.limit_zero = (limit_eff == '0);

  // Result source selection.
  always_comb begin
    case (cmd_i.res_sel)
      etf_pkg::RES_ZERO:      res_d = '0;
      etf_pkg::RES_TEST:      res_d = {{(etf_pkg::CountW-etf_pkg::TestW){1'b0}},
                                       prod_q[etf_pkg::TestW-1:0]};
      etf_pkg::RES_COUNT:     res_d = count_q;
      etf_pkg::RES_COUNT_INC: res_d = count_q + etf_pkg::CountW'(1);
      default:                res_d = '0;
    endcase
  end

  // Payload registers; the controller sequences every load.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_xy) begin
      x_q <= pixel_x_i;
      y_q <= pixel_y_i;
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_ext;
    end
    if (cmd_i.cr_load) begin
      cr_q <= etf_pkg::sat_word({{(etf_pkg::AccW-etf_pkg::WordW){cfg_i.origin_real[etf_pkg::WordW-1]}},
                                 cfg_i.origin_real} + prod_ext);
    end
    if (cmd_i.ci_load) begin
      ci_q <= etf_pkg::sat_word({{(etf_pkg::AccW-etf_pkg::WordW){cfg_i.origin_imag[etf_pkg::WordW-1]}},
                                 cfg_i.origin_imag} + prod_ext);
    end
    // Power accumulator: start from z (or one), then one complex product a pass.
    if (cmd_i.p_load) begin
      if (cmd_i.p_one) begin
        pr_q <= etf_pkg::OneFix;
        pi_q <= '0;
      end else begin
        pr_q <= zr_q;
        pi_q <= zi_q;
      end
    end
    if (cmd_i.pr_cmul) begin
      pr_q <= etf_pkg::shift_sat(diff_val);
    end
    if (cmd_i.pi_cmul) begin
      pi_q <= etf_pkg::shift_sat(sum_val);
    end
    // Orbit update: z = z^e - c, saturated per component.
    if (cmd_i.z_clear) begin
      zr_q <= '0;
      zi_q <= '0;
    end else if (cmd_i.z_update) begin
      zr_q <= etf_pkg::sat_word({{(etf_pkg::AccW-etf_pkg::WordW){pr_q[etf_pkg::WordW-1]}}, pr_q} -
                                {{(etf_pkg::AccW-etf_pkg::WordW){cr_q[etf_pkg::WordW-1]}}, cr_q});
      zi_q <= etf_pkg::sat_word({{(etf_pkg::AccW-etf_pkg::WordW){pi_q[etf_pkg::WordW-1]}}, pi_q} -
                                {{(etf_pkg::AccW-etf_pkg::WordW){ci_q[etf_pkg::WordW-1]}}, ci_q});
    end
    if (cmd_i.cnt_clear) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + etf_pkg::CountW'(1);
    end
    if (cmd_i.res_load) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign iteration_count_o = out_q;

endmodule

// ===== hw/rtl/etf_ctrl.sv =====
// Controller of the escape-time fractal pixel block: sequences the shared
// multiplier, the iteration loop and both handshakes. Depends on etf_pkg.
module etf_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  etf_pkg::mode_e            cfg_mode_i,
  input  logic [etf_pkg::ExpW-1:0]  cfg_exponent_i,
  input  etf_pkg::sts_t             sts_i,
  output etf_pkg::cmd_t             cmd_o
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_CR_MUL   = 17'h00002,
    S_CR_ADD   = 17'h00004,
    S_CI_ADD   = 17'h00008,
    S_LOADP    = 17'h00010,
    S_CM_A     = 17'h00020,
    S_CM_B     = 17'h00040,
    S_CM_C     = 17'h00080,
    S_CM_D     = 17'h00100,
    S_CM_E     = 17'h00200,
    S_ZUPD     = 17'h00400,
    S_SQ_A     = 17'h00800,
    S_SQ_B     = 17'h01000,
    S_SQ_C     = 17'h02000,
    S_TEST_MUL = 17'h04000,
    S_TEST_RES = 17'h08000,
    S_DONE     = 17'h10000
  } state_e;

  state_e                    state_q, state_d;
  logic [etf_pkg::ExpW-1:0]  k_q, k_d, e_eff;
  logic                      out_valid_q, out_valid_d;
  etf_pkg::cmd_t             cmd;

  // Effective exponent: two in quadratic mode, else the register clamped.
  always_comb begin
    if (cfg_mode_i == etf_pkg::MODE_QUAD) begin
      e_eff = etf_pkg::ExpW'(2);
    end else if (cfg_exponent_i > etf_pkg::ExpW'(etf_pkg::MaxExponent)) begin
      e_eff = etf_pkg::ExpW'(etf_pkg::MaxExponent);
    end else begin
      e_eff = cfg_exponent_i;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cmd         = '0;
    cmd.mul_sel = etf_pkg::MUL_ZR_ZR;
    cmd.res_sel = etf_pkg::RES_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_xy   = 1'b1;
          cmd.z_clear   = 1'b1;
          cmd.cnt_clear = 1'b1;
          case (cfg_mode_i)
            etf_pkg::MODE_ZERO: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = etf_pkg::RES_ZERO;
              state_d      = S_DONE;
            end
            etf_pkg::MODE_TEST: state_d = S_TEST_MUL;
            default:            state_d = S_CR_MUL;
          endcase
        end
      end
      // Point c = origin + coordinate * step, one component a cycle.
      S_CR_MUL: begin
        cmd.mul_sel = etf_pkg::MUL_X_SR;
        state_d     = S_CR_ADD;
      end
      S_CR_ADD: begin
        cmd.cr_load = 1'b1;
        cmd.mul_sel = etf_pkg::MUL_Y_SI;
        state_d     = S_CI_ADD;
      end
      S_CI_ADD: begin
        cmd.ci_load = 1'b1;
        if (sts_i.limit_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = etf_pkg::RES_COUNT;
          state_d      = S_DONE;
        end else begin
          state_d = S_LOADP;
        end
      end
      // Start of one iteration: seed the power with z, or with one.
      S_LOADP: begin
        cmd.p_load = 1'b1;
        cmd.p_one  = (e_eff == '0);
        if (e_eff >= etf_pkg::ExpW'(2)) begin
          k_d     = e_eff - etf_pkg::ExpW'(1);
          state_d = S_CM_A;
        end else begin
          state_d = S_ZUPD;
        end
      end
      // One complex product p = p * z, states S_CM_A through S_CM_E.
      S_CM_A: begin
        cmd.mul_sel = etf_pkg::MUL_PR_ZR;
        state_d     = S_CM_B;
      end
      S_CM_B: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = etf_pkg::MUL_PI_ZI;
        state_d      = S_CM_C;
      end
      S_CM_C: begin
        cmd.pr_cmul = 1'b1;
        cmd.mul_sel = etf_pkg::MUL_PR_ZI;
        state_d     = S_CM_D;
      end
      S_CM_D: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = etf_pkg::MUL_PI_ZR;
        state_d      = S_CM_E;
      end
      S_CM_E: begin
        cmd.pi_cmul = 1'b1;
        if (k_q == etf_pkg::ExpW'(1)) begin
          state_d = S_ZUPD;
        end else begin
          k_d     = k_q - etf_pkg::ExpW'(1);
          state_d = S_CM_A;
        end
      end
      S_ZUPD: begin
        cmd.z_update = 1'b1;
        state_d      = S_SQ_A;
      end
      // Escape test on the squared magnitude of the new z.
      S_SQ_A: begin
        cmd.mul_sel = etf_pkg::MUL_ZR_ZR;
        state_d     = S_SQ_B;
      end
      S_SQ_B: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = etf_pkg::MUL_ZI_ZI;
        state_d      = S_SQ_C;
      end
      S_SQ_C: begin
        if (sts_i.escaped) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = etf_pkg::RES_COUNT;
          state_d      = S_DONE;
        end else if (sts_i.cnt_last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = etf_pkg::RES_COUNT_INC;
          state_d      = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_d     = S_LOADP;
        end
      end
      // Test pattern: low byte of the coordinate product.
      S_TEST_MUL: begin
        cmd.mul_sel = etf_pkg::MUL_XY;
        state_d     = S_TEST_RES;
      end
      S_TEST_RES: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = etf_pkg::RES_TEST;
        state_d      = S_DONE;
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag: set on load, cleared once the item is taken.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ===== hw/rtl/escape_time_fractal_pixel.sv =====
// Escape-time fractal pixel engine. Each item is one pixel coordinate; the
// block forms c = origin + coordinate * step and iterates z = z^e - c from
// zero in signed Q6.26 until |z|^2 >= 2 or the iteration limit, returning
// the escaping step's index (or the limit). All products go through one
// shared 32x32 multiplier. Items are worked on one at a time; a finished
// result waits in the output register while the next item is accepted.
// Configuration should only be written while the block is idle.
// Depends on etf_pkg, etf_cfg, etf_ctrl, etf_dp and the assertion macros.
`include "escape_time_fractal_pixel_macros.svh"

module escape_time_fractal_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [etf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [etf_pkg::WordW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [etf_pkg::CoordW-1:0]    pixel_x_i,
  input  logic [etf_pkg::CoordW-1:0]    pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [etf_pkg::CountW-1:0]    iteration_count_o
);

  etf_pkg::cfg_t cfg;
  etf_pkg::cmd_t cmd;
  etf_pkg::sts_t sts;

  // Configuration registers.
  etf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  etf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cfg_mode_i     (cfg.mode),
    .cfg_exponent_i (cfg.exponent),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // Arithmetic and result registers.
  etf_dp u_dp (
    .clk_i             (clk_i),
    .cfg_i             (cfg),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .iteration_count_o (iteration_count_o)
  );

  // An accepted item keeps the block busy in the following cycle.
  `ETF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item accepted but block not busy next cycle")

  // The output register is only overwritten when free or being emptied.
  `ETF_ASSERT_IMPL(a_out_load_free, clk_i, rst_ni, cmd.out_load, !out_valid_o || !out_stall_i, "output register overwritten while holding an item")

  // The iteration count only advances when the pixel neither escaped nor hit the limit.
  `ETF_ASSERT_IMPL(a_cnt_inc_legal, clk_i, rst_ni, cmd.cnt_inc, !sts.escaped && !sts.cnt_last, "iteration count advanced past termination")

endmodule

// ===== tb/tb_escape_time_fractal_pixel.sv =====
// Self-checking testbench for escape_time_fractal_pixel: drives pixel coordinates and register
// writes, predicts each iteration count with its own fixed-point model, and checks every result.
// Depends on etf_pkg and the escape_time_fractal_pixel RTL only.
module tb_escape_time_fractal_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [etf_pkg::WordW-1:0] word_t;
  typedef logic signed [etf_pkg::AccW:0]    wide_t;
  typedef logic [etf_pkg::CoordW-1:0]       coord_t;
  typedef logic [etf_pkg::CountW-1:0]       count_t;

  typedef struct {
    coord_t x;
    coord_t y;
    count_t count;
  } pixel_result_t;

  localparam int unsigned HoldCycles = 300;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [etf_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [etf_pkg::WordW-1:0]   cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  coord_t                      pixel_x_i;
  coord_t                      pixel_y_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  count_t                      iteration_count_o;

  etf_pkg::cfg_t model_cfg;
  pixel_result_t pending_counts[$];
  int unsigned   mismatch_count = 0;
  bit            src_idle_on    = 1'b1;
  bit            sink_idle_on   = 1'b1;
  bit            sink_hold_req  = 1'b0;

  escape_time_fractal_pixel dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .iteration_count_o (iteration_count_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp a wide signed value to the 32-bit word range.
  function automatic word_t sat_to_word(input wide_t v);
    word_t top, bottom;
    wide_t hi, lo;
    top    = {1'b0, {(etf_pkg::WordW-1){1'b1}}};
    bottom = {1'b1, {(etf_pkg::WordW-1){1'b0}}};
    hi     = wide_t'(top);
    lo     = wide_t'(bottom);
    if (v > hi) return top;
    if (v < lo) return bottom;
    return v[etf_pkg::WordW-1:0];
  endfunction

  // Complex product with exact sums, floor shift by the fraction width and saturation.
  function automatic void complex_mul(input word_t ar, ai, br, bi, output word_t rr, ri);
    wide_t war, wai, wbr, wbi;
    war = wide_t'(ar);
    wai = wide_t'(ai);
    wbr = wide_t'(br);
    wbi = wide_t'(bi);
    rr  = sat_to_word((war * wbr - wai * wbi) >>> etf_pkg::FracBits);
    ri  = sat_to_word((war * wbi + wai * wbr) >>> etf_pkg::FracBits);
  endfunction

  // Escape when the exact sum of squares reaches 2.0.
  function automatic bit has_escaped(input word_t zr, zi);
    wide_t r, m;
    r = wide_t'(zr);
    m = wide_t'(zi);
    return (r * r + m * m) >= (wide_t'(2) <<< (2 * etf_pkg::FracBits));
  endfunction

  // Iterate z = z^e - c from zero; return the escaping step's index or the limit.
  function automatic count_t escape_count(input word_t cr, ci, input int unsigned e, lim);
    word_t       zr, zi, pr, pi, tr, ti;
    wide_t       wa, wb;
    int unsigned i, k;
    zr = '0;
    zi = '0;
    for (i = 0; i < lim; i++) begin
      if (e == 0) begin
        pr = sat_to_word(wide_t'(1) <<< etf_pkg::FracBits);
        pi = '0;
      end else begin
        pr = zr;
        pi = zi;
        for (k = 1; k < e; k++) begin
          complex_mul(pr, pi, zr, zi, tr, ti);
          pr = tr;
          pi = ti;
        end
      end
      wa = wide_t'(pr);
      wb = wide_t'(cr);
      zr = sat_to_word(wa - wb);
      wa = wide_t'(pi);
      wb = wide_t'(ci);
      zi = sat_to_word(wa - wb);
      if (has_escaped(zr, zi)) return etf_pkg::CountW'(i);
    end
    return etf_pkg::CountW'(lim);
  endfunction

  // Expected iteration count of one pixel under the given register settings.
  function automatic count_t predict_count(input etf_pkg::cfg_t c, input coord_t x, y);
    wide_t       wx, wy, orr, ori, sr, si;
    logic [15:0] prod;
    int unsigned lim, e;
    case (c.mode)
      etf_pkg::MODE_TEST: begin
        prod = 16'(x[7:0]) * 16'(y[7:0]);
        return etf_pkg::CountW'(prod[7:0]);
      end
      etf_pkg::MODE_QUAD, etf_pkg::MODE_POWER: begin
        wx  = wide_t'(x);
        wy  = wide_t'(y);
        orr = wide_t'(c.origin_real);
        ori = wide_t'(c.origin_imag);
        sr  = wide_t'(c.step_real);
        si  = wide_t'(c.step_imag);
        lim = (c.iteration_limit > etf_pkg::LimitCap) ? 32'(etf_pkg::LimitCap) :
                                                        32'(c.iteration_limit);
        e   = 2;
        if (c.mode == etf_pkg::MODE_POWER) begin
          e = (32'(c.exponent) > etf_pkg::MaxExponent) ? etf_pkg::MaxExponent :
                                                         32'(c.exponent);
        end
        return escape_count(sat_to_word(orr + wx * sr), sat_to_word(ori + wy * si), e, lim);
      end
      default: return '0;
    endcase
  endfunction

  // Mostly coordinates inside a 256-pixel window, sometimes anywhere.
  function automatic coord_t pick_coord();
    if ($urandom_range(0, 4) != 0) return etf_pkg::CoordW'($urandom_range(0, 255));
    return etf_pkg::CoordW'($urandom);
  endfunction

  // Per-pixel increment spanning at most one unit over the window, either sign.
  function automatic word_t pick_step();
    int s;
    s = int'($urandom_range(1 << 12, 1 << 18));
    if ($urandom_range(0, 1) != 0) s = -s;
    return s;
  endfunction

  task automatic flag_count_mismatch(input string what, input pixel_result_t want,
                                     input count_t got);
    mismatch_count++;
    $display("%0t ns: %s at pixel (%0d, %0d): count %0d, predicted %0d",
             $time, what, want.x, want.y, got, want.count);
  endtask

  // Register write; the enable drops for a cycle so that writes never overlap.
  task automatic write_reg(input logic [etf_pkg::CfgIdxW-1:0] idx,
                           input logic [etf_pkg::WordW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      etf_pkg::RegOriginReal: model_cfg.origin_real     = val;
      etf_pkg::RegOriginImag: model_cfg.origin_imag     = val;
      etf_pkg::RegStepReal:   model_cfg.step_real       = val;
      etf_pkg::RegStepImag:   model_cfg.step_imag       = val;
      etf_pkg::RegIterLimit:  model_cfg.iteration_limit = val[etf_pkg::CountW-1:0];
      etf_pkg::RegMode:       model_cfg.mode            = etf_pkg::mode_e'(val[1:0]);
      etf_pkg::RegExponent:   model_cfg.exponent        = val[etf_pkg::ExpW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_config(input etf_pkg::cfg_t c);
    write_reg(etf_pkg::RegOriginReal, c.origin_real);
    write_reg(etf_pkg::RegOriginImag, c.origin_imag);
    write_reg(etf_pkg::RegStepReal, c.step_real);
    write_reg(etf_pkg::RegStepImag, c.step_imag);
    write_reg(etf_pkg::RegIterLimit, etf_pkg::WordW'(c.iteration_limit));
    write_reg(etf_pkg::RegMode, etf_pkg::WordW'(c.mode));
    write_reg(etf_pkg::RegExponent, etf_pkg::WordW'(c.exponent));
  endtask

  // Offer one pixel item, optionally after a gap, and record its predicted count on acceptance.
  task automatic send_pixel(input coord_t x, y);
    pixel_result_t item;
    if (src_idle_on && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    item.x     = x;
    item.y     = y;
    item.count = predict_count(model_cfg, x, y);
    pending_counts.push_back(item);
  endtask

  // Stop offering and wait until every predicted count has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Registers straight out of reset: c is zero, so every pixel runs to the default limit.
  task automatic test_reset_state();
    drain_results();
    send_pixel('0, '0);
    send_pixel('1, '1);
  endtask

  task automatic test_zero_mode();
    drain_results();
    write_reg(etf_pkg::RegMode, etf_pkg::WordW'(etf_pkg::MODE_ZERO));
    send_pixel('0, '0);
    send_pixel('1, '1);
  endtask

  task automatic test_pattern_mode();
    drain_results();
    write_reg(etf_pkg::RegMode, etf_pkg::WordW'(etf_pkg::MODE_TEST));
    send_pixel('0, '0);
    send_pixel('1, '1);
    send_pixel(16'h00FF, 16'h0101);
    send_pixel(16'hA5C3, 16'h5A3C);
  endtask

  // Zero limit, limits at and above the cap, saturated c at both ends, and a bounded point.
  task automatic test_quadratic_edges();
    drain_results();
    write_reg(etf_pkg::RegMode, etf_pkg::WordW'(etf_pkg::MODE_QUAD));
    write_reg(etf_pkg::RegIterLimit, '0);
    send_pixel(16'd5, 16'd7);
    drain_results();
    write_reg(etf_pkg::RegIterLimit, 32'h000F_FFFF);
    write_reg(etf_pkg::RegOriginReal, 32'h0800_0000);
    send_pixel('0, '0);
    drain_results();
    write_reg(etf_pkg::RegIterLimit, etf_pkg::WordW'(etf_pkg::LimitCap));
    write_reg(etf_pkg::RegOriginReal, 32'h7FFF_FFFF);
    write_reg(etf_pkg::RegStepReal, 32'h7FFF_FFFF);
    send_pixel('1, '0);
    drain_results();
    write_reg(etf_pkg::RegOriginReal, 32'h8000_0000);
    write_reg(etf_pkg::RegStepReal, 32'h8000_0000);
    write_reg(etf_pkg::RegOriginImag, 32'h8000_0000);
    write_reg(etf_pkg::RegStepImag, 32'h7FFF_FFFF);
    send_pixel('1, '1);
    drain_results();
    // Origin -1.0 with 1/64 steps: column 128 lands on c = 1.0, which stays bounded.
    write_reg(etf_pkg::RegIterLimit, 32'd40);
    write_reg(etf_pkg::RegOriginReal, 32'hFC00_0000);
    write_reg(etf_pkg::RegOriginImag, '0);
    write_reg(etf_pkg::RegStepReal, 32'h0010_0000);
    write_reg(etf_pkg::RegStepImag, 32'h0010_0000);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'd128, 16'd0);
    send_pixel(16'd100, 16'd30);
  endtask

  // Exponent zero, one, ordinary powers, the maximum and values clamped to it.
  task automatic test_power_exponents();
    int unsigned exps[7] = '{0, 1, 3, 5, 8, 9, 15};
    int unsigned k;
    drain_results();
    write_reg(etf_pkg::RegMode, etf_pkg::WordW'(etf_pkg::MODE_POWER));
    write_reg(etf_pkg::RegIterLimit, 32'd12);
    write_reg(etf_pkg::RegOriginReal, 32'hFE00_0000);
    write_reg(etf_pkg::RegOriginImag, 32'hFF00_0000);
    for (k = 0; k < 7; k++) begin
      drain_results();
      write_reg(etf_pkg::RegExponent, etf_pkg::WordW'(exps[k]));
      send_pixel(etf_pkg::CoordW'(exps[k] * 5), 16'd20);
    end
  endtask

  // The result side holds off for a long stretch while fast items keep coming.
  task automatic test_output_backpressure();
    int unsigned k;
    drain_results();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(etf_pkg::RegMode, etf_pkg::WordW'(etf_pkg::MODE_TEST));
    sink_hold_req = 1'b1;
    for (k = 0; k < 24; k++) begin
      send_pixel(etf_pkg::CoordW'($urandom), etf_pkg::CoordW'($urandom));
    end
    drain_results();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Phases of random register settings, each followed by a batch of pixels.
  task automatic test_random_views(input int unsigned total);
    etf_pkg::cfg_t c;
    int unsigned   sent, phase_len, kind, k;
    bit            quiet;
    sent = 0;
    while (sent < total) begin
      drain_results();
      quiet        = (total - sent) <= 150;
      src_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
      sink_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      kind         = $urandom_range(0, 19);
      // Fully random registers unless a view below overrides them.
      c.origin_real     = $urandom;
      c.origin_imag     = $urandom;
      c.step_real       = $urandom;
      c.step_imag       = $urandom;
      c.iteration_limit = etf_pkg::CountW'($urandom_range(0, 40));
      c.mode            = etf_pkg::mode_e'($urandom_range(0, 3));
      c.exponent        = etf_pkg::ExpW'($urandom_range(0, 15));
      if (kind <= 1) begin
        c.mode = etf_pkg::MODE_ZERO;
      end else if (kind <= 4) begin
        c.mode = etf_pkg::MODE_TEST;
      end else if (kind == 5) begin
        // Real part of c at 4.0 or more: every pixel escapes at once, so large limits are cheap.
        c.origin_real     = $urandom_range(1 << 28, 32'h7FFF_FFFF);
        c.step_real       = $urandom_range(0, 1 << 20);
        c.iteration_limit = etf_pkg::CountW'($urandom_range(1000, 20'hF_FFFF));
        c.mode            = ($urandom_range(0, 1) != 0) ? etf_pkg::MODE_QUAD :
                                                          etf_pkg::MODE_POWER;
      end else if (kind >= 7) begin
        c.origin_real = -(5 << 25) + int'($urandom_range(0, 7 << 25));
        c.origin_imag = -(3 << 25) + int'($urandom_range(0, 3 << 26));
        c.step_real   = pick_step();
        c.step_imag   = pick_step();
        if (kind <= 13) begin
          c.mode            = etf_pkg::MODE_QUAD;
          c.iteration_limit = ($urandom_range(0, 7) == 0) ? '0 :
                              etf_pkg::CountW'($urandom_range(1, 48));
        end else begin
          c.mode            = etf_pkg::MODE_POWER;
          c.iteration_limit = etf_pkg::CountW'($urandom_range(1, 24));
        end
      end
      load_config(c);
      phase_len = $urandom_range(20, 60);
      if (phase_len > total - sent) phase_len = total - sent;
      for (k = 0; k < phase_len; k++) send_pixel(pick_coord(), pick_coord());
      sent += phase_len;
    end
  endtask

  // Result side: random stall bursts, plus one long hold when requested.
  initial begin : result_sink
    int unsigned hold_left, burst_left;
    hold_left   = 0;
    burst_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left != 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (sink_idle_on && $urandom_range(0, 7) == 0) burst_left = $urandom_range(1, 19);
      end
    end
  end

  // Compare each accepted count with the oldest prediction.
  always @(posedge clk_i) begin : count_checker
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        want = '{x: '0, y: '0, count: '0};
        flag_count_mismatch("result with no item outstanding", want, iteration_count_o);
      end else begin
        want = pending_counts.pop_front();
        if (iteration_count_o !== want.count) begin
          flag_count_mismatch("wrong iteration count", want, iteration_count_o);
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    pixel_x_i   <= '0;
    pixel_y_i   <= '0;
    model_cfg   = '{origin_real: '0, origin_imag: '0, step_real: '0, step_imag: '0,
                    iteration_limit: etf_pkg::LimitRst, mode: etf_pkg::MODE_QUAD,
                    exponent: etf_pkg::ExpRst};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_zero_mode();
    test_pattern_mode();
    test_quadratic_edges();
    test_power_exponents();
    test_output_backpressure();
    test_random_views(1060);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin : watchdog
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/etf_pkg.sv
hw/rtl/etf_cfg.sv
hw/rtl/etf_dp.sv
hw/rtl/etf_ctrl.sv
hw/rtl/escape_time_fractal_pixel.sv
tb/tb_escape_time_fractal_pixel.sv
